### src/quic_version_negotiation_builder_unit_assert.svh
// Assertion macros used by the checker of the version negotiation builder.
`ifndef QUIC_VERSION_NEGOTIATION_BUILDER_UNIT_ASSERT_SVH
`define QUIC_VERSION_NEGOTIATION_BUILDER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QVNB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QVNB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/qvnb_pkg.sv
// Shared types and constants for the version negotiation packet builder.
package qvnb_pkg;

  localparam int MAX_CID_LEN_DEF  = 20;
  localparam int MAX_VERSIONS_DEF = 64;

  localparam logic [15:0] CAPACITY_RST   = 16'd1200;
  localparam logic [6:0]  FIRST_LOW_RST  = 7'd0;
  localparam logic        LONG_HDR_BIT   = 1'b1;

  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_DCID  = 2'd1,
    ACT_SCID  = 2'd2,
    ACT_VER   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_BEGIN = 2'd1,
    ST_NO_ROOM   = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    CFG_FIRST_LOW = 1'b0,
    CFG_CAPACITY  = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'd0,
    S_BAD   = 4'd1,
    S_FIRST = 4'd2,
    S_ZERO  = 4'd3,
    S_SLEN  = 4'd4,
    S_SCID  = 4'd5,
    S_DLEN  = 4'd6,
    S_DCID  = 4'd7,
    S_VER   = 4'd8
  } fsm_state_t;

  typedef enum logic [2:0] {
    BS_FIRST = 3'd0,
    BS_ZERO  = 3'd1,
    BS_SLEN  = 3'd2,
    BS_SCID  = 3'd3,
    BS_DLEN  = 3'd4,
    BS_DCID  = 3'd5,
    BS_VER   = 3'd6
  } byte_sel_t;

  typedef enum logic [1:0] {
    CH_ONE  = 2'd0,
    CH_FOUR = 2'd1,
    CH_SRC  = 2'd2,
    CH_DST  = 2'd3
  } chunk_t;

  // Selection driven from the state alone.
  typedef struct packed {
    byte_sel_t byte_sel;
    chunk_t    chunk;
  } dp_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch;       // item accepted: capture the word, clear the byte index
    logic    begin_ok;
    logic    begin_bad;
    logic    store_dcid;
    logic    store_scid;
    logic    emit;        // load a packet byte into the output register
    logic    emit_err;    // load an error result instead
    status_t err_status;
    logic    idx_clr;
    logic    idx_inc;
    logic    hdr_done;
    logic    dec_vleft;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t action;
    logic    begin_bad;
    logic    open;
    logic    over_cap;
    logic    hdr_sent;
    logic    stall;
    logic    no_room;
    logic    idx_zero;
    logic    idx_last;
    logic    src_empty;
    logic    dst_empty;
  } dp_stat_t;

endpackage

### src/qvnb_ctrl.sv
// Controller state machine that sequences header and version bytes.
module qvnb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  qvnb_pkg::dp_stat_t  stat,
  output qvnb_pkg::dp_cmd_t   cmd,
  output qvnb_pkg::dp_sel_t   sel
);

  qvnb_pkg::fsm_state_t state_r, state_nxt;
  logic accept;
  logic fail;

  assign in_tready = (state_r == qvnb_pkg::S_IDLE);
  assign accept    = in_tvalid && in_tready;
  // A chunk is checked against the capacity before its first byte.
  assign fail      = stat.idx_zero && stat.no_room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qvnb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qvnb_pkg::S_IDLE: begin
        if (accept) begin
          if (stat.action == qvnb_pkg::ACT_BEGIN) begin
            if (stat.begin_bad) begin
              state_nxt = qvnb_pkg::S_BAD;
            end
          end else if (stat.action == qvnb_pkg::ACT_VER && stat.open && !stat.over_cap) begin
            state_nxt = stat.hdr_sent ? qvnb_pkg::S_VER : qvnb_pkg::S_FIRST;
          end
        end
      end
      qvnb_pkg::S_BAD: begin
        if (!stat.stall) begin
          state_nxt = qvnb_pkg::S_IDLE;
        end
      end
      qvnb_pkg::S_FIRST: begin
        if (!stat.stall) begin
          state_nxt = fail ? qvnb_pkg::S_IDLE : qvnb_pkg::S_ZERO;
        end
      end
      qvnb_pkg::S_ZERO: begin
        if (!stat.stall) begin
          if (fail) begin
            state_nxt = qvnb_pkg::S_IDLE;
          end else if (stat.idx_last) begin
            state_nxt = qvnb_pkg::S_SLEN;
          end
        end
      end
      qvnb_pkg::S_SLEN: begin
        if (!stat.stall) begin
          if (fail) begin
            state_nxt = qvnb_pkg::S_IDLE;
          end else begin
            state_nxt = stat.src_empty ? qvnb_pkg::S_DLEN : qvnb_pkg::S_SCID;
          end
        end
      end
      qvnb_pkg::S_SCID: begin
        if (!stat.stall) begin
          if (fail) begin
            state_nxt = qvnb_pkg::S_IDLE;
          end else if (stat.idx_last) begin
            state_nxt = qvnb_pkg::S_DLEN;
          end
        end
      end
      qvnb_pkg::S_DLEN: begin
        if (!stat.stall) begin
          if (fail) begin
            state_nxt = qvnb_pkg::S_IDLE;
          end else begin
            state_nxt = stat.dst_empty ? qvnb_pkg::S_VER : qvnb_pkg::S_DCID;
          end
        end
      end
      qvnb_pkg::S_DCID: begin
        if (!stat.stall) begin
          if (fail) begin
            state_nxt = qvnb_pkg::S_IDLE;
          end else if (stat.idx_last) begin
            state_nxt = qvnb_pkg::S_VER;
          end
        end
      end
      qvnb_pkg::S_VER: begin
        if (!stat.stall) begin
          if (fail || stat.idx_last) begin
            state_nxt = qvnb_pkg::S_IDLE;
          end
        end
      end
      default: state_nxt = qvnb_pkg::S_IDLE;
    endcase
  end

  // Byte source and chunk size follow the state only.
  always_comb begin
    sel.byte_sel = qvnb_pkg::BS_ZERO;
    sel.chunk    = qvnb_pkg::CH_ONE;
    case (state_r)
      qvnb_pkg::S_FIRST: sel.byte_sel = qvnb_pkg::BS_FIRST;
      qvnb_pkg::S_ZERO: begin
        sel.byte_sel = qvnb_pkg::BS_ZERO;
        sel.chunk    = qvnb_pkg::CH_FOUR;
      end
      qvnb_pkg::S_SLEN: sel.byte_sel = qvnb_pkg::BS_SLEN;
      qvnb_pkg::S_SCID: begin
        sel.byte_sel = qvnb_pkg::BS_SCID;
        sel.chunk    = qvnb_pkg::CH_SRC;
      end
      qvnb_pkg::S_DLEN: sel.byte_sel = qvnb_pkg::BS_DLEN;
      qvnb_pkg::S_DCID: begin
        sel.byte_sel = qvnb_pkg::BS_DCID;
        sel.chunk    = qvnb_pkg::CH_DST;
      end
      qvnb_pkg::S_VER: begin
        sel.byte_sel = qvnb_pkg::BS_VER;
        sel.chunk    = qvnb_pkg::CH_FOUR;
      end
      default: begin
        sel.byte_sel = qvnb_pkg::BS_ZERO;
        sel.chunk    = qvnb_pkg::CH_ONE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.err_status = qvnb_pkg::ST_NO_ROOM;
    case (state_r)
      qvnb_pkg::S_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          case (stat.action)
            qvnb_pkg::ACT_BEGIN: begin
              cmd.begin_bad = stat.begin_bad;
              cmd.begin_ok  = !stat.begin_bad;
            end
            qvnb_pkg::ACT_DCID: cmd.store_dcid = stat.open;
            qvnb_pkg::ACT_SCID: cmd.store_scid = stat.open;
            default: cmd.latch = 1'b1;
          endcase
        end
      end
      qvnb_pkg::S_BAD: begin
        if (!stat.stall) begin
          cmd.emit_err   = 1'b1;
          cmd.err_status = qvnb_pkg::ST_BAD_BEGIN;
        end
      end
      qvnb_pkg::S_FIRST, qvnb_pkg::S_SLEN: begin
        if (!stat.stall) begin
          cmd.emit_err = fail;
          cmd.emit     = !fail;
          cmd.idx_clr  = 1'b1;
        end
      end
      qvnb_pkg::S_DLEN: begin
        if (!stat.stall) begin
          cmd.emit_err = fail;
          cmd.emit     = !fail;
          cmd.idx_clr  = 1'b1;
          cmd.hdr_done = !fail && stat.dst_empty;
        end
      end
      qvnb_pkg::S_ZERO, qvnb_pkg::S_SCID: begin
        if (!stat.stall) begin
          cmd.emit_err = fail;
          cmd.emit     = !fail;
          cmd.idx_clr  = stat.idx_last;
          cmd.idx_inc  = !stat.idx_last;
        end
      end
      qvnb_pkg::S_DCID: begin
        if (!stat.stall) begin
          cmd.emit_err = fail;
          cmd.emit     = !fail;
          cmd.idx_clr  = stat.idx_last;
          cmd.idx_inc  = !stat.idx_last;
          cmd.hdr_done = !fail && stat.idx_last;
        end
      end
      qvnb_pkg::S_VER: begin
        if (!stat.stall) begin
          cmd.emit_err  = fail;
          cmd.emit      = !fail;
          cmd.dec_vleft = !fail && stat.idx_zero;
          cmd.idx_clr   = stat.idx_last;
          cmd.idx_inc   = !stat.idx_last;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

### src/qvnb_dp.sv
// Datapath: registers, connection-ID stores, capacity check and output register.
module qvnb_dp #(
  parameter int MAX_CID_LEN  = qvnb_pkg::MAX_CID_LEN_DEF,
  parameter int MAX_VERSIONS = qvnb_pkg::MAX_VERSIONS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [qvnb_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [qvnb_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  logic                               cfg_we,
  input  logic [qvnb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qvnb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [qvnb_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [qvnb_pkg::OUT_TUSER_W-1:0]   out_tuser,
  output logic                               out_tlast,
  input  qvnb_pkg::dp_cmd_t                  cmd,
  input  qvnb_pkg::dp_sel_t                  sel,
  output qvnb_pkg::dp_stat_t                 stat
);

  localparam int LEN_W  = $clog2(MAX_CID_LEN + 1);
  localparam int CID_AW = (MAX_CID_LEN > 1) ? $clog2(MAX_CID_LEN) : 1;
  localparam int IDX_W  = $clog2((MAX_CID_LEN > 4) ? MAX_CID_LEN : 4);
  localparam int VCNT_W = $clog2(MAX_VERSIONS + 1);

  logic [7:0]  dlen_in, slen_in, cid_in;
  logic [6:0]  count_in;
  logic [31:0] word_in;

  logic [6:0]        first_low_r, first_low_nxt;
  logic [15:0]       cap_r, cap_nxt;
  logic [LEN_W-1:0]  dlen_r, dlen_nxt, slen_r, slen_nxt;
  logic [LEN_W-1:0]  dfill_r, dfill_nxt, sfill_r, sfill_nxt;
  logic [VCNT_W-1:0] vleft_r, vleft_nxt;
  logic [15:0]       bw_r, bw_nxt;
  logic              hdr_sent_r, hdr_sent_nxt;
  logic              failed_r, failed_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              oval_r, oval_nxt;
  logic [7:0]        obyte_r;
  logic [1:0]        ostat_r;
  logic              olast_r;
  logic [31:0]       word_r;

  logic [7:0] dcid_mem [MAX_CID_LEN];
  logic [7:0] scid_mem [MAX_CID_LEN];

  logic        dcid_wr, scid_wr;
  logic [16:0] chunk_n;
  logic [7:0]  byte_mux;
  logic        last_mux;

  assign dlen_in  = in_tdata[7:0];
  assign slen_in  = in_tdata[15:8];
  assign count_in = in_tdata[22:16];
  assign cid_in   = in_tdata[30:23];
  assign word_in  = in_tdata[62:31];

  assign dcid_wr = cmd.store_dcid && !hdr_sent_r && (dfill_r < dlen_r);
  assign scid_wr = cmd.store_scid && !hdr_sent_r && (sfill_r < slen_r);

  always_comb begin
    case (sel.chunk)
      qvnb_pkg::CH_ONE:  chunk_n = 17'd1;
      qvnb_pkg::CH_FOUR: chunk_n = 17'd4;
      qvnb_pkg::CH_SRC:  chunk_n = 17'(slen_r);
      qvnb_pkg::CH_DST:  chunk_n = 17'(dlen_r);
      default:           chunk_n = 17'd1;
    endcase
  end

  always_comb begin
    last_mux = 1'b0;
    case (sel.byte_sel)
      qvnb_pkg::BS_FIRST: byte_mux = {qvnb_pkg::LONG_HDR_BIT, first_low_r};
      qvnb_pkg::BS_ZERO:  byte_mux = 8'd0;
      qvnb_pkg::BS_SLEN:  byte_mux = 8'(slen_r);
      qvnb_pkg::BS_SCID:  byte_mux = scid_mem[idx_r[CID_AW-1:0]];
      qvnb_pkg::BS_DLEN:  byte_mux = 8'(dlen_r);
      qvnb_pkg::BS_DCID:  byte_mux = dcid_mem[idx_r[CID_AW-1:0]];
      qvnb_pkg::BS_VER: begin
        case (idx_r[1:0])
          2'd0:    byte_mux = word_r[31:24];
          2'd1:    byte_mux = word_r[23:16];
          2'd2:    byte_mux = word_r[15:8];
          default: byte_mux = word_r[7:0];
        endcase
        // The count was already decremented on the first byte of this word.
        last_mux = (idx_r[1:0] == 2'd3) && (vleft_r == '0);
      end
      default: byte_mux = 8'd0;
    endcase
  end

  always_comb begin
    stat.action    = qvnb_pkg::action_t'(in_tuser);
    stat.begin_bad = ({1'b0, dlen_in} > 9'(MAX_CID_LEN)) ||
                     ({1'b0, slen_in} > 9'(MAX_CID_LEN)) ||
                     (count_in == 7'd0) ||
                     ({2'b0, count_in} > 9'(MAX_VERSIONS));
    stat.open      = (vleft_r != '0) && !failed_r;
    stat.over_cap  = bw_r > cap_r;
    stat.hdr_sent  = hdr_sent_r;
    stat.stall     = oval_r && !out_tready;
    stat.no_room   = (17'(bw_r) + chunk_n) > 17'(cap_r);
    stat.idx_zero  = (idx_r == '0);
    stat.idx_last  = (17'(idx_r) + 17'd1) == chunk_n;
    stat.src_empty = (slen_r == '0);
    stat.dst_empty = (dlen_r == '0);
  end

  always_comb begin
    first_low_nxt = first_low_r;
    cap_nxt       = cap_r;
    dlen_nxt      = dlen_r;
    slen_nxt      = slen_r;
    dfill_nxt     = dfill_r;
    sfill_nxt     = sfill_r;
    vleft_nxt     = vleft_r;
    bw_nxt        = bw_r;
    hdr_sent_nxt  = hdr_sent_r;
    failed_nxt    = failed_r;
    idx_nxt       = idx_r;
    oval_nxt      = oval_r && !out_tready;

    if (cfg_we) begin
      case (qvnb_pkg::cfg_reg_t'(cfg_index))
        qvnb_pkg::CFG_FIRST_LOW: first_low_nxt = cfg_wdata[6:0];
        qvnb_pkg::CFG_CAPACITY:  cap_nxt       = cfg_wdata;
        default:                 cap_nxt       = cap_r;
      endcase
    end

    if (cmd.begin_ok) begin
      dlen_nxt     = LEN_W'(dlen_in);
      slen_nxt     = LEN_W'(slen_in);
      vleft_nxt    = VCNT_W'(count_in);
      bw_nxt       = 16'd0;
      dfill_nxt    = '0;
      sfill_nxt    = '0;
      hdr_sent_nxt = 1'b0;
      failed_nxt   = 1'b0;
    end
    if (cmd.begin_bad || cmd.emit_err) begin
      failed_nxt = 1'b1;
      vleft_nxt  = '0;
    end
    if (dcid_wr) dfill_nxt = dfill_r + LEN_W'(1);
    if (scid_wr) sfill_nxt = sfill_r + LEN_W'(1);
    if (cmd.dec_vleft) vleft_nxt = vleft_r - VCNT_W'(1);
    if (cmd.hdr_done) hdr_sent_nxt = 1'b1;
    if (cmd.emit) bw_nxt = bw_r + 16'd1;
    if (cmd.latch || cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    if (cmd.emit || cmd.emit_err) oval_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_low_r <= qvnb_pkg::FIRST_LOW_RST;
      cap_r       <= qvnb_pkg::CAPACITY_RST;
      dlen_r      <= '0;
      slen_r      <= '0;
      dfill_r     <= '0;
      sfill_r     <= '0;
      vleft_r     <= '0;
      bw_r        <= 16'd0;
      hdr_sent_r  <= 1'b0;
      failed_r    <= 1'b0;
      idx_r       <= '0;
      oval_r      <= 1'b0;
    end else begin
      first_low_r <= first_low_nxt;
      cap_r       <= cap_nxt;
      dlen_r      <= dlen_nxt;
      slen_r      <= slen_nxt;
      dfill_r     <= dfill_nxt;
      sfill_r     <= sfill_nxt;
      vleft_r     <= vleft_nxt;
      bw_r        <= bw_nxt;
      hdr_sent_r  <= hdr_sent_nxt;
      failed_r    <= failed_nxt;
      idx_r       <= idx_nxt;
      oval_r      <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) word_r <= word_in;
    if (dcid_wr) dcid_mem[dfill_r[CID_AW-1:0]] <= cid_in;
    if (scid_wr) scid_mem[sfill_r[CID_AW-1:0]] <= cid_in;
    if (cmd.emit_err) begin
      obyte_r <= 8'd0;
      ostat_r <= cmd.err_status;
      olast_r <= 1'b1;
    end else if (cmd.emit) begin
      obyte_r <= byte_mux;
      ostat_r <= qvnb_pkg::ST_OK;
      olast_r <= last_mux;
    end
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = obyte_r;
  assign out_tuser  = ostat_r;
  assign out_tlast  = olast_r;

endmodule

### src/quic_version_negotiation_builder_unit.sv
// The first packet byte is registered after the first version word moves the controller to
// its first-byte state. Begin and CID items are taken while idle; no item is taken while
// version bytes, the first word's with the header, go out one byte a cycle unless stalled.
// A full output register stalls the byte sequencer until the item is taken.
// Reset (synchronous, active low) clears all control state, sets capacity to 1200 and the
// header low bits to zero; the CID stores are not cleared.
module quic_version_negotiation_builder_unit #(
  parameter int MAX_CID_LEN  = qvnb_pkg::MAX_CID_LEN_DEF,
  parameter int MAX_VERSIONS = qvnb_pkg::MAX_VERSIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // From bit 0: dest_cid_len[7:0], src_cid_len[15:8], version_count[22:16],
  // cid_byte[30:23], version_word[62:31], zero pad [63].
  input  logic [qvnb_pkg::IN_TDATA_W-1:0]   in_tdata,
  // From bit 0: action[1:0].
  input  logic [qvnb_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  logic                              cfg_we,
  input  logic [qvnb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qvnb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // From bit 0: out_byte[7:0].
  output logic [qvnb_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // From bit 0: status[1:0].
  output logic [qvnb_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                              out_tlast
);

  // The controller walks the packet layout: first byte, four zero bytes for the
  // version field, source CID length and bytes, destination CID length and bytes,
  // then the four bytes of each version word. Before the first byte of every chunk
  // the datapath compares the bytes written plus the chunk size against the
  // capacity; a chunk that does not fit becomes a single error item.
  qvnb_pkg::dp_cmd_t  cmd;
  qvnb_pkg::dp_sel_t  sel;
  qvnb_pkg::dp_stat_t stat;

  qvnb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd),
    .sel       (sel)
  );

  // The datapath holds the packet state, both CID stores and the output register,
  // so the next item can be taken while a finished byte still waits downstream.
  qvnb_dp #(
    .MAX_CID_LEN  (MAX_CID_LEN),
    .MAX_VERSIONS (MAX_VERSIONS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sel        (sel),
    .stat       (stat)
  );

endmodule

### src/qvnb_checker.sv
// Port-level checker for the version negotiation builder, bound to the top level.
`include "quic_version_negotiation_builder_unit_assert.svh"

module qvnb_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [qvnb_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic [qvnb_pkg::IN_TUSER_W-1:0]   in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [qvnb_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [qvnb_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input logic                              out_tlast
);

  logic good_begin;
  logic is_err;

  assign good_begin = in_tvalid && in_tready && (in_tuser == qvnb_pkg::ACT_BEGIN) &&
                      ({1'b0, in_tdata[7:0]} <= 9'(qvnb_pkg::MAX_CID_LEN_DEF)) &&
                      ({1'b0, in_tdata[15:8]} <= 9'(qvnb_pkg::MAX_CID_LEN_DEF)) &&
                      (in_tdata[22:16] != 7'd0) &&
                      ({2'b0, in_tdata[22:16]} <= 9'(qvnb_pkg::MAX_VERSIONS_DEF));
  assign is_err = out_tvalid && (out_tuser != qvnb_pkg::ST_OK);

  `QVNB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "output item dropped while stalled")
  `QVNB_ASSERT_NOW(a_err_last, clk, rst_n, is_err, out_tlast, "error item without last")
  `QVNB_ASSERT_NOW(a_err_zero, clk, rst_n, is_err, out_tdata == 8'd0, "error item with nonzero byte")
  `QVNB_ASSERT_NEXT(a_begin_ready, clk, rst_n, good_begin, in_tready, "valid begin left input blocked")
  `QVNB_ASSERT_NOW(a_rst_quiet, clk, rst_n, $past(!rst_n), !out_tvalid, "output valid just after reset")

endmodule

bind quic_version_negotiation_builder_unit qvnb_checker u_qvnb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
